### hw/rtl/cpd_pkg.sv
package cpd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int MAG_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS + 2;
    localparam int ROOT_W = SQ_W + 1;

    localparam int DIST_W = 17;
    localparam int SEEN_W = 11;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [SQ_W-1:0]   SQ_ALL_ONES = {SQ_W{1'b1}};
    localparam logic [ROOT_W-1:0] SQ_BIT0     = ROOT_W'(1) << (SQ_W - 2);

    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } t_req;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } t_point;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic pop;
        logic wr;
        logic issue;
        logic sq_start;
        logic sq_step;
        logic out_load;
    } t_bctl;

    // difference needs one bit more than the magnitude to keep its sign
    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic [MAG_W:0] d;
        logic [MAG_W:0] m;
        d = {{2{a[COORD_BITS-1]}}, a} - {{2{b[COORD_BITS-1]}}, b};
        m = d[MAG_W] ? (~d + (MAG_W+1)'(1)) : d;
        return m[MAG_W-1:0];
    endfunction

endpackage

### hw/rtl/cpd_ram.sv
module cpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/cpd_front.sv
module cpd_front
    import cpd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    output logic                         o_full,
    output t_req                         o_req,
    input  logic                         i_pop
);

    t_point            r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              wr;
    logic              rd;

    assign o_full = (r_cnt == QCNT_W'(QDEPTH));
    assign wr     = i_push && !o_full;
    assign rd     = i_pop && (r_cnt != '0);

    // queue slot count and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (rd) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= '{x: i_point_x, y: i_point_y, last: i_last_point};
        end
    end

    always_comb begin
        o_req.valid = (r_cnt != '0);
        o_req.x     = r_q[r_rp].x;
        o_req.y     = r_q[r_rp].y;
        o_req.last  = r_q[r_rp].last;
    end

endmodule

### hw/rtl/cpd_back.sv
module cpd_back
    import cpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req,
    output logic              o_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [DIST_W-1:0] o_min_distance,
    output logic              o_no_pair,
    output logic [SEEN_W-1:0] o_points_seen,
    output logic              o_capacity_overflow
);

    t_state r_state;
    t_state n_state;
    t_bctl  ctl;

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_scan_n;
    logic [IDX_W-1:0]             r_idx;
    logic                         r_ovf;
    logic                         r_last;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic [SQ_W-1:0]              r_best;

    logic                         r_v1, r_v2, r_v3, r_v4;
    logic [MAG_W-1:0]             r_dx, r_dy;
    logic [SQ_W-1:0]              r_sx, r_sy, r_sum;

    logic [ROOT_W-1:0]            r_rem, r_root, r_bit;
    logic [ROOT_W-1:0]            trial;
    logic                         take;

    logic                         r_ovalid;
    logic [DIST_W-1:0]            r_odist;
    logic                         r_onopair;
    logic [SEEN_W-1:0]            r_oseen;
    logic                         r_oovf;

    logic [COORD_BITS-1:0]        x_rd, y_rd;
    logic                         set_full;
    logic                         scan_end;
    logic                         busy;
    logic                         slot_free;

    assign set_full  = (r_count == CNT_W'(MAX_POINTS));
    assign scan_end  = (CNT_W'(r_idx) == r_scan_n - CNT_W'(1));
    assign busy      = r_v1 || r_v2 || r_v3 || r_v4;
    assign slot_free = !r_ovalid || i_pop;

    cpd_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (ctl.wr),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_req.x),
        .i_raddr (r_idx),
        .o_rdata (x_rd)
    );

    cpd_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (ctl.wr),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_req.y),
        .i_raddr (r_idx),
        .o_rdata (y_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (!set_full && r_count != '0) begin
                        n_state = ST_SCAN;
                    end else if (i_req.last) begin
                        n_state = ST_SQRT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!busy) begin
                    n_state = r_last ? ST_SQRT : ST_IDLE;
                end
            end
            ST_SQRT: begin
                if (r_bit[0]) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl          = '0;
        ctl.pop      = (r_state == ST_IDLE) && i_req.valid;
        ctl.wr       = ctl.pop && !set_full;
        ctl.issue    = (r_state == ST_SCAN);
        ctl.sq_start = (n_state == ST_SQRT) && (r_state != ST_SQRT);
        ctl.sq_step  = (r_state == ST_SQRT);
        ctl.out_load = (r_state == ST_OUT) && slot_free;
    end

    assign o_pop = ctl.pop;

    assign trial = r_root + r_bit;
    assign take  = (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_best   <= SQ_ALL_ONES;
            r_ovf    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= ctl.issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            if (ctl.pop) begin
                if (set_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (r_v4 && r_sum < r_best) begin
                r_best <= r_sum;
            end
            if (ctl.out_load) begin
                r_ovalid <= 1'b1;
                r_count  <= '0;
                r_best   <= SQ_ALL_ONES;
                r_ovf    <= 1'b0;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath: scan pipeline, square root, result register
    always_ff @(posedge i_clk) begin
        if (ctl.pop) begin
            r_px     <= i_req.x;
            r_py     <= i_req.y;
            r_last   <= i_req.last;
            r_idx    <= '0;
            r_scan_n <= r_count;
        end else if (ctl.issue) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_dx  <= abs_diff(r_px, x_rd);
        r_dy  <= abs_diff(r_py, y_rd);
        r_sx  <= r_dx * r_dx;
        r_sy  <= r_dy * r_dy;
        r_sum <= r_sx + r_sy;
        if (ctl.sq_start) begin
            r_rem  <= ROOT_W'(r_best);
            r_root <= '0;
            r_bit  <= SQ_BIT0;
        end else if (ctl.sq_step) begin
            if (take) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (ctl.out_load) begin
            r_odist   <= r_root[DIST_W-1:0];
            r_onopair <= (r_count < CNT_W'(2));
            r_oseen   <= SEEN_W'(r_count);
            r_oovf    <= r_ovf;
        end
    end

    assign o_empty             = !r_ovalid;
    assign o_min_distance      = r_odist;
    assign o_no_pair           = r_onopair;
    assign o_points_seen       = r_oseen;
    assign o_capacity_overflow = r_oovf;

endmodule

### hw/rtl/closest_pair_distance.sv
// throughput is bound by the one read port of the point memories, one stored point a cycle
// the last point of a set adds 17 square-root steps and a load of the result register
// reset clears the request queue, point count, running minimum and overflow flag
// the point memories are not cleared, only entries below the count are read
module closest_pair_distance
    import cpd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // point requests
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    // result requests
    output logic                         empty,
    input  logic                         pop,
    output logic [DIST_W-1:0]            o_min_distance,
    output logic                         o_no_pair,
    output logic [SEEN_W-1:0]            o_points_seen,
    output logic                         o_capacity_overflow
);

    // front end: short request queue, so points are taken while the back end scans
    t_req req;
    logic req_pop;

    cpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .o_full       (full),
        .o_req        (req),
        .i_pop        (req_pop)
    );

    // back end: unless the set is full, compares the new point with every stored
    // one through a read / diff / square / sum / compare pipeline and stores it,
    // and on the last point of a set takes the integer square root of the least
    // squared distance one result bit per cycle into a result register
    cpd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req               (req),
        .o_pop               (req_pop),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_min_distance      (o_min_distance),
        .o_no_pair           (o_no_pair),
        .o_points_seen       (o_points_seen),
        .o_capacity_overflow (o_capacity_overflow)
    );

endmodule
